[hw/rtl/fqd_pkg.sv]
// Package for the first-in first-out queue with delete.
// Holds the queue sizes, command and status codes, beat structs and sequencer states.
// No dependencies.
`default_nettype none

package fqd_pkg;

    // Queue sizing. The entry offset must address every entry, and the length
    // field is five bits wide.
    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = 5;
    localparam int TAG_W       = 32;

    // Command codes carried by an input beat.
    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_DELETE  = 2'd2;

    // Status codes carried by a result beat.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // One input beat.
    typedef struct packed {
        logic [1:0]       command;
        logic [TAG_W-1:0] item_value;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic [1:0]       status;
        logic [TAG_W-1:0] head_value;
        logic [CNT_W-1:0] entry_total;
    } t_out_beat;

    // Access request from the sequencer to the entry store.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [TAG_W-1:0]  wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } t_store_req;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/fqd_store.sv]
// Entry store of the queue: one write port and one registered read port.
// Depends on fqd_pkg.
`default_nettype none

module fqd_store (
    input  wire                       i_clk,
    input  fqd_pkg::t_store_req       i_req,
    output logic [fqd_pkg::TAG_W-1:0] o_rd_data
);
    import fqd_pkg::*;

    logic [TAG_W-1:0] r_mem [QUEUE_DEPTH];

    // Write when asked; read every cycle into the registered output.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        o_rd_data <= r_mem[i_req.rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/fifo_queue_with_delete.sv]
// First-in first-out queue of 32-bit tags with dequeue and delete-first-match.
// One item at a time. Enqueue, no-op and any command on an empty queue go through the start
// and done states only. Dequeue and a delete that hits: one compare per cycle from the head,
// then one entry moved per cycle to close the gap; a delete miss compares every entry. The
// single store read port sets this pace. Input is taken again once the result is in the output
// register. Reset (sync, active low) empties the queue.
`default_nettype none

module fifo_queue_with_delete (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  fqd_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output fqd_pkg::t_out_beat o_out_data
);
    import fqd_pkg::*;

    t_state            r_state, n_state;
    logic [1:0]        r_cmd;
    logic [TAG_W-1:0]  r_tag;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic              r_chk_vld, n_chk_vld;
    logic [ADDR_W-1:0] r_chk_off, n_chk_off;
    logic              r_sh_vld, n_sh_vld;
    logic [ADDR_W-1:0] r_sh_off, n_sh_off;
    logic [1:0]        r_res_status, n_res_status;
    logic [TAG_W-1:0]  r_res_head, n_res_head;
    logic              r_out_vld;
    t_out_beat         r_out;

    t_store_req        store_req;
    logic [TAG_W-1:0]  rd_data;
    logic              in_take;
    logic              out_free;
    logic              issue;
    logic              hit;
    logic              last_chk;
    logic              full;

    fqd_store u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Shared compare unit: a dequeue takes the head entry, a delete the first equal tag.
    assign issue    = (r_ptr < r_count);
    assign hit      = r_chk_vld && ((r_cmd == CMD_DEQUEUE) || (rd_data == r_tag));
    assign last_chk = ({{(CNT_W-ADDR_W){1'b0}}, r_chk_off} + CNT_W'(1)) == r_count;
    assign full     = (r_count >= CNT_W'(QUEUE_DEPTH));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if ((r_cmd inside {CMD_DEQUEUE, CMD_DELETE}) && r_count != '0) begin
                    n_state = S_SEARCH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_state = S_SHIFT;
                end else if (r_chk_vld && last_chk) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (!issue && !r_sh_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and store requests for each state.
    always_comb begin
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_chk_vld    = 1'b0;
        n_chk_off    = r_chk_off;
        n_sh_vld     = 1'b0;
        n_sh_off     = r_sh_off;
        n_res_status = r_res_status;
        n_res_head   = r_res_head;
        store_req    = '0;
        case (r_state)
            S_START: begin
                n_res_head = '0;
                n_ptr      = '0;
                case (r_cmd)
                    CMD_ENQUEUE: begin
                        if (full) begin
                            n_res_status = ST_FULL;
                        end else begin
                            store_req.wr_en   = 1'b1;
                            store_req.wr_addr = r_count[ADDR_W-1:0];
                            store_req.wr_data = r_tag;
                            n_count           = r_count + CNT_W'(1);
                            n_res_status      = ST_OK;
                        end
                    end
                    CMD_DEQUEUE, CMD_DELETE: begin
                        n_res_status = (r_count == '0) ? ST_MISS : ST_OK;
                    end
                    default: n_res_status = ST_OK;
                endcase
            end
            S_SEARCH: begin
                // Read ahead one entry while the previous one is compared.
                store_req.rd_addr = r_ptr[ADDR_W-1:0];
                if (hit) begin
                    n_res_status = ST_OK;
                    n_res_head   = (r_cmd == CMD_DEQUEUE) ? rd_data : '0;
                    n_ptr        = {{(CNT_W-ADDR_W){1'b0}}, r_chk_off} + CNT_W'(1);
                end else if (r_chk_vld && last_chk) begin
                    n_res_status = ST_MISS;
                end else begin
                    n_chk_vld = issue;
                    n_chk_off = r_ptr[ADDR_W-1:0];
                    if (issue) begin
                        n_ptr = r_ptr + CNT_W'(1);
                    end
                end
            end
            S_SHIFT: begin
                // Read entry k+1 and write it back at k on the next cycle.
                store_req.rd_addr = r_ptr[ADDR_W-1:0];
                store_req.wr_en   = r_sh_vld;
                store_req.wr_addr = r_sh_off;
                store_req.wr_data = rd_data;
                n_sh_vld          = issue;
                n_sh_off          = r_ptr[ADDR_W-1:0] - ADDR_W'(1);
                if (issue) begin
                    n_ptr = r_ptr + CNT_W'(1);
                end
                if (!issue && !r_sh_vld) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_chk_vld <= 1'b0;
            r_sh_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_chk_vld <= n_chk_vld;
            r_sh_vld  <= n_sh_vld;
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_chk_off    <= n_chk_off;
        r_sh_off     <= n_sh_off;
        r_res_status <= n_res_status;
        r_res_head   <= n_res_head;
        if (in_take) begin
            r_cmd <= i_in_data.command;
            r_tag <= i_in_data.item_value;
        end
        if (r_state == S_DONE && out_free) begin
            r_out.status      <= r_res_status;
            r_out.head_value  <= r_res_head;
            r_out.entry_total <= r_count;
        end
    end

    // The entry count never exceeds the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // A full status is only reported with the queue at its depth.
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_FULL) |->
        (o_out_data.entry_total == CNT_W'(QUEUE_DEPTH)))
        else $error("full status with queue not full");

    // The count moves only when an enqueue starts or a removal finishes.
    a_count_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
        ($past(r_state) == S_START || $past(r_state) == S_SHIFT))
        else $error("entry count changed outside enqueue or removal");

endmodule

`default_nettype wire

[bench/fifo_queue_with_delete_tb.sv]
// Self-checking testbench for the tag queue with enqueue, dequeue and delete-first-match.
// Depends on fqd_pkg for the beat structs, command and status codes and the queue depth.
// Holds a predictor of the queue, a driver and a monitor with random idling on both channels.
`default_nettype none

module fifo_queue_with_delete_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fqd_pkg::*;

    // The unused command code is a no-op that reports the current length.
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam int RANDOM_ITEMS   = 1030;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int IDLE_LIMIT     = 4000;
    localparam int PRINT_LIMIT    = 40;

    typedef struct {
        t_in_beat beat;
        bit       wait_drain;
    } t_queued_cmd;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_data;

    // Predictor state and the results it has worked out but not yet seen.
    logic [TAG_W-1:0] held_tags[$];
    t_out_beat        due_results[$];
    t_queued_cmd      command_backlog[$];

    int error_count  = 0;
    int results_seen = 0;

    fifo_queue_with_delete dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Clock and a single reset pulse at the start of the run.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Applies one command to the held tags and returns the result beat it causes.
    function automatic t_out_beat apply_command(input t_in_beat beat);
        t_out_beat res;
        bit        found;
        res = '0;
        res.status = ST_OK;
        found = 1'b0;
        case (beat.command)
            CMD_ENQUEUE: begin
                if (held_tags.size() >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    held_tags.push_back(beat.item_value);
                end
            end
            CMD_DEQUEUE: begin
                if (held_tags.size() == 0) begin
                    res.status = ST_MISS;
                end else begin
                    res.head_value = held_tags.pop_front();
                end
            end
            CMD_DELETE: begin
                for (int k = 0; k < held_tags.size() && !found; k++) begin
                    if (held_tags[k] == beat.item_value) begin
                        held_tags.delete(k);
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    res.status = ST_MISS;
                end
            end
            default: begin
            end
        endcase
        res.entry_total = CNT_W'(held_tags.size());
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [TAG_W-1:0] got,
                                   input logic [TAG_W-1:0] want);
        if (error_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                     want);
        end
        error_count++;
    endtask

    task automatic push_command(input logic [1:0] cmd, input logic [TAG_W-1:0] tag,
                                input bit wait_drain);
        t_queued_cmd entry;
        entry.beat.command    = cmd;
        entry.beat.item_value = tag;
        entry.wait_drain      = wait_drain;
        command_backlog.push_back(entry);
    endtask

    // Driver: offers beats from the backlog in bursts separated by random gaps.
    int          burst_left = 1;
    int          gap_left   = 0;
    t_queued_cmd next_cmd;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                due_results.push_back(apply_command(i_in_data));
            end
            if (i_in_valid && o_in_stall) begin
                // The offered beat is held until the block takes it.
            end else if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (command_backlog.size() != 0 &&
                         !(command_backlog[0].wait_drain && due_results.size() != 0)) begin
                next_cmd = command_backlog.pop_front();
                i_in_data  <= next_cmd.beat;
                i_in_valid <= 1'b1;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random segments of several patterns, plus long hold-offs.
    int stall_mode     = 0;
    int segment_left   = 0;
    int holdoff_left   = 0;
    int holdoffs_done  = 0;
    int next_holdoff_at = 300;

    always @(posedge i_clk) begin
        if (holdoff_left != 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else if (holdoffs_done < 2 && results_seen >= next_holdoff_at) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoffs_done++;
            next_holdoff_at += 450;
            i_out_stall <= 1'b1;
        end else begin
            if (segment_left == 0) begin
                stall_mode   = $urandom_range(4);
                segment_left = $urandom_range(20, 200);
            end else begin
                segment_left--;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(99) < 25);
                2: i_out_stall <= ($urandom_range(99) < 75);
                3: i_out_stall <= segment_left[0];
                default: i_out_stall <= (segment_left % 8) < 5;
            endcase
        end
    end

    // Monitor: each accepted result beat is checked against the oldest due result.
    t_out_beat want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (due_results.size() == 0) begin
                report_mismatch("result beat with nothing due", o_out_data.head_value, '0);
            end else begin
                want = due_results.pop_front();
                if (o_out_data.status !== want.status) begin
                    report_mismatch("status", TAG_W'(o_out_data.status), TAG_W'(want.status));
                end
                if (o_out_data.head_value !== want.head_value) begin
                    report_mismatch("head_value", o_out_data.head_value, want.head_value);
                end
                if (o_out_data.entry_total !== want.entry_total) begin
                    report_mismatch("entry_total", TAG_W'(o_out_data.entry_total),
                                    TAG_W'(want.entry_total));
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] no beat moved for %0d cycles", $realtime, IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Random tag: mostly from a small pool so that deletes hit and duplicates occur.
    logic [TAG_W-1:0] tag_pool[8];

    function automatic logic [TAG_W-1:0] pick_tag(input int pool_pct);
        if ($urandom_range(99) < pool_pct) begin
            return tag_pool[$urandom_range(7)];
        end
        return $urandom;
    endfunction

    // Stimulus and end of run.
    int enq_pct[4] = '{80, 20, 40, 35};
    int deq_pct[4] = '{10, 45, 25, 15};

    initial begin
        int         random_count;
        int         phase_kind;
        int         phase_len;
        int         roll;
        logic [1:0] cmd;
        random_count = 0;
        foreach (tag_pool[i]) begin
            tag_pool[i] = $urandom;
        end
        tag_pool[0] = '0;
        tag_pool[7] = '1;

        // Directed: empty-queue misses, the no-op, extreme tags, duplicates, deletes
        // at head, middle and miss, then dequeues down to empty again.
        push_command(CMD_DEQUEUE, 32'h0000_0000, 1'b0);
        push_command(CMD_DELETE,  32'h0000_0000, 1'b0);
        push_command(CMD_NOP,     32'hFFFF_FFFF, 1'b0);
        push_command(CMD_ENQUEUE, 32'h0000_0000, 1'b0);
        push_command(CMD_ENQUEUE, 32'hFFFF_FFFF, 1'b0);
        push_command(CMD_ENQUEUE, 32'hA5A5_A5A5, 1'b0);
        push_command(CMD_ENQUEUE, 32'hFFFF_FFFF, 1'b0);
        push_command(CMD_ENQUEUE, 32'h5A5A_5A5A, 1'b0);
        push_command(CMD_NOP,     32'h1234_5678, 1'b0);
        push_command(CMD_DELETE,  32'hFFFF_FFFF, 1'b0);
        push_command(CMD_DELETE,  32'h1234_5678, 1'b0);
        push_command(CMD_DELETE,  32'h0000_0000, 1'b0);
        push_command(CMD_DELETE,  32'h5A5A_5A5A, 1'b0);
        push_command(CMD_DEQUEUE, 32'hFFFF_FFFF, 1'b0);
        push_command(CMD_DEQUEUE, 32'h0000_0000, 1'b0);
        push_command(CMD_DEQUEUE, 32'h0000_0000, 1'b0);
        push_command(CMD_DELETE,  32'hA5A5_A5A5, 1'b0);

        // Random phases with shifting mixes; the first one fills the queue past full.
        while (random_count < RANDOM_ITEMS) begin
            phase_kind = (random_count == 0) ? 0 : $urandom_range(3);
            phase_len  = $urandom_range(30, 90);
            for (int n = 0; n < phase_len && random_count < RANDOM_ITEMS; n++) begin
                roll = $urandom_range(99);
                if (roll < enq_pct[phase_kind]) begin
                    cmd = CMD_ENQUEUE;
                end else if (roll < enq_pct[phase_kind] + deq_pct[phase_kind]) begin
                    cmd = CMD_DEQUEUE;
                end else if (roll < 97) begin
                    cmd = CMD_DELETE;
                end else begin
                    cmd = CMD_NOP;
                end
                push_command(cmd, pick_tag((cmd == CMD_DELETE) ? 80 : 60),
                             random_count == 400 || random_count == 850);
                random_count++;
            end
        end

        // Wait for the backlog and every due result before the verdict.
        @(posedge i_clk);
        while (command_backlog.size() != 0 || i_in_valid || due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (QUEUE_DEPTH + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
